[sv/ir_remote_manchester_encoder_top_macros.svh]
// ----------------------------------------------------------------------------
// ir remote manchester encoder assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef IR_REMOTE_MANCHESTER_ENCODER_TOP_MACROS_SVH
`define IR_REMOTE_MANCHESTER_ENCODER_TOP_MACROS_SVH

// same-cycle implication
`define IRME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/irme_pkg.sv]
// ----------------------------------------------------------------------------
// irme_pkg
// shared types and constants of the ir remote manchester encoder
// ----------------------------------------------------------------------------
package irme_pkg;

    localparam int MAX_BITS    = 28;
    localparam int PROTO_W     = 2;
    localparam int BIT_COUNT_W = 5;
    localparam int PAYLOAD_W   = 28;
    localparam int REG_W       = 16;
    localparam int DUR_W       = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int TRAILER_IDX = 3;

    // protocol codes
    localparam logic [PROTO_W-1:0] PROTO_RC5        = 2'd0;
    localparam logic [PROTO_W-1:0] PROTO_RC5X       = 2'd1;
    localparam logic [PROTO_W-1:0] PROTO_RC6        = 2'd2;
    localparam logic [PROTO_W-1:0] PROTO_HEADERLESS = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RC5_HALF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RC6_HDR_MARK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RC6_HDR_SPC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RC6_HALF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_HALF     = 3'd4;

    // register reset values
    localparam logic [REG_W-1:0] RST_RC5_HALF     = 16'd889;
    localparam logic [REG_W-1:0] RST_RC6_HDR_MARK = 16'd2666;
    localparam logic [REG_W-1:0] RST_RC6_HDR_SPC  = 16'd889;
    localparam logic [REG_W-1:0] RST_RC6_HALF     = 16'd444;
    localparam logic [REG_W-1:0] RST_ALT_HALF     = 16'd500;

    typedef struct packed {
        logic [REG_W-1:0] rc5_half;
        logic [REG_W-1:0] rc6_lead_mark;
        logic [REG_W-1:0] rc6_hdr_spc;
        logic [REG_W-1:0] rc6_half;
        logic [REG_W-1:0] alt_half;
    } timing_t;

    typedef struct packed {
        logic             last;
        logic [DUR_W-1:0] duration;
        logic             level;
    } seg_t;

endpackage

[sv/irme_seg_gen.sv]
// ----------------------------------------------------------------------------
// irme_seg_gen
// segment sequencer: preamble segments (none for the headerless form), then one data
// bit per two segments shifted out msb first, then the closing space
// ----------------------------------------------------------------------------
`include "ir_remote_manchester_encoder_top_macros.svh"

module irme_seg_gen #(
    parameter int MAX_BITS = irme_pkg::MAX_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  irme_pkg::timing_t                 timing,
    input  logic                              start,
    input  logic [irme_pkg::PROTO_W-1:0]      protocol,
    input  logic [irme_pkg::BIT_COUNT_W-1:0]  bit_count,
    input  logic [irme_pkg::PAYLOAD_W-1:0]    payload,
    output logic                              idle,
    output logic                              seg_valid,
    output irme_pkg::seg_t                    seg,
    input  logic                              adv
);

    localparam int CNT_W = $clog2(MAX_BITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HEAD = 4'b0010,
        ST_BITS = 4'b0100,
        ST_END  = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [irme_pkg::PROTO_W-1:0] proto_reg;
    logic [MAX_BITS-1:0]          data_reg;
    logic [CNT_W-1:0]             left_reg;
    logic [2:0]                   pos_reg;
    logic                         phase_reg;
    logic [1:0]                   head_reg;

    logic [irme_pkg::BIT_COUNT_W-1:0] n_clamp;
    logic [CNT_W-1:0]                 n_bits;
    logic [CNT_W-1:0]                 shamt;
    logic [MAX_BITS-1:0]              aligned;
    logic [irme_pkg::REG_W-1:0]       half;
    logic [1:0]                       head_end;
    logic                             first;
    logic                             trailer;

    // clamp bit count to 1..MAX_BITS, left-align the data so the msb is on top
    always_comb
    begin
        if (bit_count == '0)
            n_clamp = irme_pkg::BIT_COUNT_W'(1);
        else if (bit_count > irme_pkg::BIT_COUNT_W'(MAX_BITS))
            n_clamp = irme_pkg::BIT_COUNT_W'(MAX_BITS);
        else
            n_clamp = bit_count;
        n_bits  = CNT_W'(n_clamp);
        shamt   = CNT_W'(MAX_BITS) - n_bits;
        aligned = payload[MAX_BITS-1:0] << shamt;
    end

    always_comb
    begin
        case (proto_reg) inside
            irme_pkg::PROTO_RC5, irme_pkg::PROTO_RC5X: half = timing.rc5_half;
            irme_pkg::PROTO_RC6:                       half = timing.rc6_half;
            default:                                   half = timing.alt_half;
        endcase
        head_end = (proto_reg == irme_pkg::PROTO_RC6) ? 2'd3 : 2'd2;
        trailer  = (proto_reg == irme_pkg::PROTO_RC6) &&
                   (pos_reg == 3'(irme_pkg::TRAILER_IDX));
        // rc5 sends a 1 as space first, the others as mark first
        first    = ((proto_reg == irme_pkg::PROTO_RC5) ||
                    (proto_reg == irme_pkg::PROTO_RC5X)) ? ~data_reg[MAX_BITS-1]
                                                         : data_reg[MAX_BITS-1];
    end

    // segment presented this cycle
    always_comb
    begin
        seg.last     = 1'b0;
        seg.level    = 1'b0;
        seg.duration = {1'b0, half};
        unique case (state_reg)
            ST_HEAD:
            begin
                unique case (proto_reg)
                    irme_pkg::PROTO_RC5X:
                        seg.level = (head_reg != 2'd2);
                    irme_pkg::PROTO_RC6:
                    begin
                        seg.level = ~head_reg[0];
                        if (head_reg == 2'd0)
                            seg.duration = {1'b0, timing.rc6_lead_mark};
                        else if (head_reg == 2'd1)
                            seg.duration = {1'b0, timing.rc6_hdr_spc};
                    end
                    default:
                        seg.level = ~head_reg[0];
                endcase
            end
            ST_BITS:
            begin
                seg.level = first ^ phase_reg;
                if (trailer)
                    seg.duration = {half, 1'b0};
            end
            ST_END:
            begin
                seg.duration = '0;
                seg.last     = 1'b1;
            end
            default:
                seg.duration = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = (protocol == irme_pkg::PROTO_HEADERLESS) ? ST_BITS
                                                                         : ST_HEAD;
            ST_HEAD:
                if (adv && head_reg == head_end)
                    state_next = ST_BITS;
            ST_BITS:
                if (adv && phase_reg && left_reg == CNT_W'(1))
                    state_next = ST_END;
            ST_END:
                if (adv)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            proto_reg <= irme_pkg::PROTO_RC5;
            left_reg  <= '0;
            pos_reg   <= '0;
            phase_reg <= 1'b0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                proto_reg <= protocol;
                left_reg  <= n_bits;
                pos_reg   <= '0;
                phase_reg <= 1'b0;
                head_reg  <= '0;
            end
            else if (adv)
            begin
                if (state_reg == ST_HEAD)
                    head_reg <= head_reg + 2'd1;
                if (state_reg == ST_BITS)
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        left_reg <= left_reg - CNT_W'(1);
                        if (pos_reg != 3'(irme_pkg::TRAILER_IDX + 1))
                            pos_reg <= pos_reg + 3'd1;
                    end
                end
            end
        end
    end

    // data shift register, one bit per finished bit cell
    always_ff @(posedge clk)
    begin
        if (start)
            data_reg <= aligned;
        else if (adv && state_reg == ST_BITS && phase_reg)
            data_reg <= data_reg << 1;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign seg_valid = !idle;

    `IRME_ASSERT_NEXT(a_start_busy, start, state_reg != ST_IDLE, "command lost at start")
    `IRME_ASSERT_NOW(a_bits_left, state_reg == ST_BITS, left_reg != '0, "bit counter underrun")
    `IRME_ASSERT_NOW(a_adv_valid, adv, seg_valid, "segment taken while none pending")

endmodule

[sv/ir_remote_manchester_encoder_top.sv]
// ----------------------------------------------------------------------------
// ir_remote_manchester_encoder_top
// rc5 / rc6 biphase frame encoder: one command in, a run of mark/space
// segments out, closed by a zero-length space flagged with tlast
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                    content
//  s_axis    in   s_axis_tvalid/tready         one command per item
//  m_axis    out  m_axis_tvalid/tready         one segment per item
//  cfg       in   cfg_valid/cfg_ready          timing register write
//
//  a command is loaded into the sequencer, which then emits head + 2 * bits + 1
//  segments: head is 3 for rc5 forms, 4 for rc6 and 0 for the headerless form,
//  so at most 61 segments with 28 bits
//  the segments come from the segment sequencer, which emits one segment
//  per cycle from the data shift register while m_axis is not stalled
//  a stalled m_axis holds the sequencer; the next command is taken once the
//  closing space sits in the output register
//  reset brings the timing registers to their default values
//
`include "ir_remote_manchester_encoder_top_macros.svh"

module ir_remote_manchester_encoder_top #(
    parameter int MAX_BITS = irme_pkg::MAX_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [39:0]                      s_axis_tdata,  // bit_count, payload, zero pad
    input  logic [irme_pkg::PROTO_W-1:0]     s_axis_tuser,  // protocol
    // segment stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // level, duration_us, zero pad
    output logic                             m_axis_tlast,  // last
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [irme_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [irme_pkg::REG_W-1:0]       cfg_data
);

    irme_pkg::timing_t timing_reg;
    irme_pkg::seg_t    gen_seg;
    irme_pkg::seg_t    out_seg_reg;
    logic              out_valid_reg, out_valid_next;
    logic              gen_idle;
    logic              gen_valid;
    logic              take;
    logic              start;

    // registers are always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.rc5_half      <= irme_pkg::RST_RC5_HALF;
            timing_reg.rc6_lead_mark <= irme_pkg::RST_RC6_HDR_MARK;
            timing_reg.rc6_hdr_spc   <= irme_pkg::RST_RC6_HDR_SPC;
            timing_reg.rc6_half      <= irme_pkg::RST_RC6_HALF;
            timing_reg.alt_half      <= irme_pkg::RST_ALT_HALF;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                irme_pkg::REG_RC5_HALF:     timing_reg.rc5_half      <= cfg_data;
                irme_pkg::REG_RC6_HDR_MARK: timing_reg.rc6_lead_mark <= cfg_data;
                irme_pkg::REG_RC6_HDR_SPC:  timing_reg.rc6_hdr_spc   <= cfg_data;
                irme_pkg::REG_RC6_HALF:     timing_reg.rc6_half      <= cfg_data;
                irme_pkg::REG_ALT_HALF:     timing_reg.alt_half      <= cfg_data;
                default:                    ;  // writes past the list are dropped
            endcase
        end
    end

    // one command at a time
    assign s_axis_tready = gen_idle;
    assign start         = s_axis_tvalid && s_axis_tready;

    irme_seg_gen #(
        .MAX_BITS (MAX_BITS)
    ) u_seg_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .timing    (timing_reg),
        .start     (start),
        .protocol  (s_axis_tuser),
        .bit_count (s_axis_tdata[4:0]),
        .payload   (s_axis_tdata[32:5]),
        .idle      (gen_idle),
        .seg_valid (gen_valid),
        .seg       (gen_seg),
        .adv       (take)
    );

    // output register: refills in the same cycle the sink drains it
    assign take = gen_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_seg_reg <= gen_seg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_seg_reg.duration, out_seg_reg.level};
    assign m_axis_tlast  = out_seg_reg.last;

    // the closing space is a zero-length space
    `IRME_ASSERT_NOW(a_last_empty, m_axis_tvalid && m_axis_tlast,
        m_axis_tdata[17:0] == 18'd0, "closing segment is not a zero-length space")
    // while idle, only the closing space may still wait at the output
    `IRME_ASSERT_NOW(a_idle_tail, s_axis_tready && m_axis_tvalid && !m_axis_tready,
        m_axis_tlast, "frame body still pending while accepting a command")
    // an item taken from the sequencer shows up at the output next cycle
    `IRME_ASSERT_NEXT(a_take_shown, take, m_axis_tvalid, "segment dropped from output register")

endmodule
